### hw/rtl/chnhist_pkg.sv
// Package: request codes for the channel histogram block.
`timescale 1ns / 1ps

package chnhist_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Fixed input layout of the slave-side tdata
  localparam int SAMPLE_W     = 8;
  localparam int NUM_SAMPLES  = 4;
  localparam int RD_CH_LSB    = 32;
  localparam int RD_BIN_LSB   = 34;
  localparam int IN_DATA_W    = 48;

endpackage

### hw/rtl/chnhist_bin_ram.sv
// Module: simple dual-port bin memory, one write and one registered read per cycle.
`timescale 1ns / 1ps

module chnhist_bin_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/chnhist_divider.sv
// Module: iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module chnhist_divider #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [FRAC_BITS:0]    quotient,
  output logic                  done
);

  localparam int SW = $clog2(FRAC_BITS + 2);

  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [SW-1:0]         steps;
  logic                  busy;
  logic                  ge;
  logic [COUNT_BITS:0]   rem_sub;

  // The count never exceeds the divisor, so the quotient fits in FRAC_BITS+1 bits
  // and the first step works on the count itself.
  always_comb begin
    ge      = (rem >= {1'b0, dvs});
    rem_sub = ge ? (rem - {1'b0, dvs}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dvs      <= divisor;
      quotient <= '0;
      steps    <= SW'(FRAC_BITS + 1);
    end else if (busy) begin
      rem      <= {rem_sub[COUNT_BITS-1:0], 1'b0};
      quotient <= {quotient[FRAC_BITS-1:0], ge};
      steps    <= steps - SW'(1);
    end
  end

endmodule

### hw/rtl/channel_histogram_normalized_core.sv
// Top level: per-channel bin histogram with normalized read-out.
//
//  Channel  Dir  Signals              Contents (lowest bit up)
//  s_       in   tvalid tready tdata  sample_0..3, read_channel, read_bin
//                tuser                req_type
//  m_       out  tvalid tready tdata  bin_fraction, bin_count
//                tuser                no_pixels
//  cfg_     in   wr_en wr_data        channels_in_use
//
// Add pixel: for each enabled channel the bin RAM reads one channel while it writes
// back the previous one. Read: the divider's loop produces one quotient bit per
// cycle. Reset and a clear request sweep all 2^(channel bits + bin bits) bin RAM
// entries (1024 at default), with s_tready low.
// A finished result waits in the output register; only the next result stalls on it.
`timescale 1ns / 1ps

module channel_histogram_normalized_core #(
  parameter int NUM_BINS     = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int COUNT_BITS   = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // sample_0[7:0], sample_1[15:8], sample_2[23:16], sample_3[31:24],
  // read_channel[33:32], read_bin[41:34], zero pad
  input  logic [chnhist_pkg::IN_DATA_W-1:0]            s_tdata,
  // req_type[1:0]
  input  logic [1:0]                                   s_tuser,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // bin_fraction[FRAC_BITS:0], bin_count above it, zero pad
  output logic [((FRAC_BITS+1+COUNT_BITS+7)/8)*8-1:0]  m_tdata,
  // no_pixels[0]
  output logic [0:0]                                   m_tuser,
  input  logic                                         cfg_wr_en,
  input  logic [2:0]                                   cfg_wr_data
);

  localparam int OUT_W  = ((FRAC_BITS + 1 + COUNT_BITS + 7) / 8) * 8;
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int ADDR_W = CH_W + BIN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_RD_DATA,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                state;
  logic [2:0]            channels_in_use;
  logic [COUNT_BITS-1:0] pixel_total;
  logic [ADDR_W-1:0]     clr_addr;
  logic [NCH_W-1:0]      n_ch;
  logic [NCH_W-1:0]      step;
  logic [BIN_W-1:0]      bin_q [MAX_CHANNELS];
  logic [ADDR_W-1:0]     prev_addr;
  logic [FRAC_BITS:0]    res_frac;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_empty;

  logic                  ram_wr_en;
  logic [ADDR_W-1:0]     ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [ADDR_W-1:0]     ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_rd_data;

  logic                  div_start;
  logic [FRAC_BITS:0]    div_quot;
  logic                  div_done;

  logic                  s_accept;
  logic [1:0]            req;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [7:0] v);
    return (int'(v) >= NUM_BINS) ? BIN_W'(NUM_BINS - 1) : v[BIN_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] clamp_ch(input logic [1:0] v);
    return (int'(v) >= MAX_CHANNELS) ? CH_W'(MAX_CHANNELS - 1) : v[CH_W-1:0];
  endfunction

  function automatic logic [NCH_W-1:0] clamp_n(input logic [2:0] v);
    logic [NCH_W-1:0] r;
    if (v == 3'd0) begin
      r = NCH_W'(1);
    end else if (int'(v) > MAX_CHANNELS) begin
      r = NCH_W'(MAX_CHANNELS);
    end else begin
      r = NCH_W'(v);
    end
    return r;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign req       = s_tuser;
  assign div_start = (state == S_RD_DATA) && (pixel_total != '0);

  // Bin RAM port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = prev_addr;
    ram_wr_data = (ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);
    ram_rd_en   = 1'b0;
    ram_rd_addr = {step[CH_W-1:0], bin_q[step[CH_W-1:0]]};
    case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      S_IDLE: begin
        if (s_accept && req == chnhist_pkg::REQ_READ) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = {clamp_ch(s_tdata[chnhist_pkg::RD_CH_LSB +: 2]),
                         clamp_bin(s_tdata[chnhist_pkg::RD_BIN_LSB +: 8])};
        end
      end
      S_ADD: begin
        // Read channel step while writing back channel step-1
        ram_rd_en = (step < n_ch);
        ram_wr_en = (step != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= 3'd3;
    end else if (cfg_wr_en) begin
      channels_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pixel_total <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept) begin
            case (req)
              chnhist_pkg::REQ_ADD: begin
                if (pixel_total != COUNT_MAX) begin
                  pixel_total <= pixel_total + COUNT_BITS'(1);
                end
                n_ch  <= clamp_n(channels_in_use);
                step  <= '0;
                state <= S_ADD;
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                  bin_q[c] <= clamp_bin(s_tdata[c*chnhist_pkg::SAMPLE_W +: 8]);
                end
              end
              chnhist_pkg::REQ_READ: begin
                state <= S_RD_DATA;
              end
              chnhist_pkg::REQ_CLEAR: begin
                pixel_total <= '0;
                clr_addr    <= '0;
                state       <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          prev_addr <= ram_rd_addr;
          step      <= step + NCH_W'(1);
          if (step == n_ch) begin
            state <= S_IDLE;
          end
        end
        S_RD_DATA: begin
          res_cnt <= ram_rd_data;
          if (pixel_total == '0) begin
            res_frac  <= '0;
            res_empty <= 1'b1;
            state     <= S_FINISH;
          end else begin
            res_empty <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_frac <= div_quot;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= OUT_W'({res_cnt, res_frac});
            m_tuser[0] <= res_empty;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  chnhist_bin_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  chnhist_divider #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rd_data),
    .divisor  (pixel_total),
    .quotient (div_quot),
    .done     (div_done)
  );

endmodule

### verif/tb_channel_histogram_normalized_core.sv
// Self-checking testbench for the channel histogram core: directed cases, then random segments.
`timescale 1ns / 1ps

module tb_channel_histogram_normalized_core;

  localparam int NUM_BINS      = 256;
  localparam int MAX_CHANNELS  = 4;
  localparam int COUNT_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam int OUT_W         = ((FRAC_BITS + 1 + COUNT_BITS + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // clear sweep of the bin RAM plus margin, and the read latency plus margin
  localparam int SWEEP_WAIT    = 1100;
  localparam int READ_WAIT     = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENT_ITEMS = 48;

  typedef struct packed {
    logic [1:0]                         req;
    logic [chnhist_pkg::NUM_SAMPLES-1:0][chnhist_pkg::SAMPLE_W-1:0] sample;
    logic [1:0]                         read_channel;
    logic [7:0]                         read_bin;
  } hist_req_t;

  typedef struct packed {
    logic [FRAC_BITS:0]    fraction;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } bin_result_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [chnhist_pkg::IN_DATA_W-1:0] s_tdata;
  logic [1:0]                        s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [OUT_W-1:0]                  m_tdata;
  logic [0:0]                        m_tuser;
  logic                              cfg_wr_en;
  logic [2:0]                        cfg_wr_data;

  channel_histogram_normalized_core #(
    .NUM_BINS     (NUM_BINS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .COUNT_BITS   (COUNT_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Histogram mirror
  logic [COUNT_BITS-1:0] hist_bins [MAX_CHANNELS][NUM_BINS];
  logic [COUNT_BITS-1:0] hist_pixels;
  logic [2:0]            hist_channels;
  bin_result_t           expected_bins[$];

  int error_count   = 0;
  int reads_checked = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  bit hold_go       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_histogram();
    for (int c = 0; c < MAX_CHANNELS; c++)
      for (int b = 0; b < NUM_BINS; b++)
        hist_bins[c][b] = '0;
    hist_pixels = '0;
  endfunction

  function automatic void update_histogram(input hist_req_t it);
    int          n;
    logic [63:0] scaled;
    logic [63:0] quotient;
    bin_result_t r;
    case (it.req)
      chnhist_pkg::REQ_ADD: begin
        n = (hist_channels == 3'd0) ? 1 :
            (hist_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(hist_channels);
        for (int c = 0; c < n; c++)
          hist_bins[c][it.sample[c]] = sat_inc(hist_bins[c][it.sample[c]]);
        hist_pixels = sat_inc(hist_pixels);
      end
      chnhist_pkg::REQ_READ: begin
        r.count  = hist_bins[it.read_channel][it.read_bin];
        r.empty  = (hist_pixels == '0);
        scaled   = 64'(r.count) << FRAC_BITS;
        quotient = r.empty ? 64'd0 : scaled / hist_pixels;
        r.fraction = quotient[FRAC_BITS:0];
        expected_bins.push_back(r);
      end
      chnhist_pkg::REQ_CLEAR: clear_histogram();
      default: ;
    endcase
  endfunction

  function automatic hist_req_t make_request(input logic [1:0] req, input logic [7:0] s0,
                                             input logic [7:0] s1, input logic [7:0] s2,
                                             input logic [7:0] s3, input logic [1:0] ch,
                                             input logic [7:0] bin);
    hist_req_t it;
    it.req          = req;
    it.sample       = {s3, s2, s1, s0};
    it.read_channel = ch;
    it.read_bin     = bin;
    return it;
  endfunction

  // Half the values land in a few hot bins at either end so counts build up
  function automatic logic [7:0] pick_value();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return 8'($urandom_range(0, 7));
    if (roll == 1) return 8'($urandom_range(248, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic hist_req_t random_request();
    hist_req_t it;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)      it.req = chnhist_pkg::REQ_ADD;
    else if (roll < 93) it.req = chnhist_pkg::REQ_READ;
    else if (roll < 96) it.req = chnhist_pkg::REQ_CLEAR;
    else                it.req = REQ_UNUSED;
    for (int c = 0; c < chnhist_pkg::NUM_SAMPLES; c++)
      it.sample[c] = pick_value();
    it.read_channel = 2'($urandom_range(0, 3));
    it.read_bin     = pick_value();
    return it;
  endfunction

  task automatic send_item(input hist_req_t it);
    logic [chnhist_pkg::IN_DATA_W-1:0] word;
    word = '0;
    word[chnhist_pkg::NUM_SAMPLES*chnhist_pkg::SAMPLE_W-1:0] = it.sample;
    word[chnhist_pkg::RD_CH_LSB +: 2]  = it.read_channel;
    word[chnhist_pkg::RD_BIN_LSB +: 8] = it.read_bin;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= it.req;
    do @(posedge clk); while (!s_tready);
    update_histogram(it);
    items_sent++;
  endtask

  task automatic source_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_results(input int extra_cycles);
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_channels(input logic [2:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    hist_channels = value;
    settings_used++;
  endtask

  // Empty reads, bin extremes, disabled channel, unused code, clear, full fraction
  task automatic test_directed_cases();
    src_idle_pct = 36;
    snk_idle_pct = 50;
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd3, 8'd255));
    send_item(make_request(REQ_UNUSED, 8'd9, 8'd9, 8'd9, 8'd9, 2'd1, 8'd9));
    send_item(make_request(chnhist_pkg::REQ_ADD, 8'd0, 8'd255, 8'd128, 8'd77, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_ADD, 8'd255, 8'd0, 8'd128, 8'd255, 2'd3,
                           8'd255));
    send_item(make_request(chnhist_pkg::REQ_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd255));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd1, 8'd255));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd1, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd2, 8'd128));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd3, 8'd255));
    send_item(make_request(chnhist_pkg::REQ_ADD, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3,
                           8'd255));
    send_item(make_request(REQ_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3, 8'd255));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd255));
    send_item(make_request(chnhist_pkg::REQ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_ADD, 8'd1, 8'd2, 8'd4, 8'd8, 2'd0, 8'd0));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 8'd1));
    send_item(make_request(chnhist_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 2'd2, 8'd4));
    source_quiet();
  endtask

  // Hold the receiver off while reads keep coming, so the input backs up
  task automatic test_output_stall();
    hist_req_t it;
    src_idle_pct = 36;
    hold_go = 1'b1;
    repeat (24) begin
      it = random_request();
      it.req = chnhist_pkg::REQ_READ;
      send_item(it);
    end
    source_quiet();
    wait_results(0);
  endtask

  // Stop sending until every read has come back, then go on
  task automatic test_drain_pause();
    hist_req_t it;
    src_idle_pct = 36;
    repeat (6) begin
      it = random_request();
      if (it.req == chnhist_pkg::REQ_CLEAR) it.req = chnhist_pkg::REQ_ADD;
      send_item(it);
    end
    source_quiet();
    wait_results(0);
    repeat (6) begin
      it = random_request();
      it.req = chnhist_pkg::REQ_READ;
      send_item(it);
    end
    source_quiet();
  endtask

  task automatic test_random_segment(input logic [2:0] channels, input int src_pct,
                                     input int snk_pct);
    hist_req_t it;
    int        counted;
    counted = 0;
    source_quiet();
    // a clear may still be sweeping after the last read came back
    wait_results(SWEEP_WAIT);
    write_channels(channels);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (counted < SEGMENT_ITEMS) begin
      it = random_request();
      send_item(it);
      if (it.req != REQ_UNUSED) counted++;
    end
    source_quiet();
  endtask

  // Receiver: random ready, or a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.fraction = m_tdata[FRAC_BITS:0];
      got.count    = m_tdata[FRAC_BITS+1 +: COUNT_BITS];
      got.empty    = m_tuser[0];
      if (expected_bins.size() == 0) begin
        $display("%0t: result with none pending: fraction %0d count %0d empty %0d",
                 $time, got.fraction, got.count, got.empty);
        error_count++;
      end else begin
        want = expected_bins.pop_front();
        reads_checked++;
        if (got.fraction !== want.fraction) begin
          $display("%0t: bin_fraction mismatch: expected %0d, actual %0d",
                   $time, want.fraction, got.fraction);
          error_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                   $time, want.count, got.count);
          error_count++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: no_pixels mismatch: expected %0d, actual %0d",
                   $time, want.empty, got.empty);
          error_count++;
        end
      end
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = chnhist_pkg::REQ_ADD;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    clear_histogram();
    hist_channels = 3'd3;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_stall();
    test_drain_pause();
    test_random_segment(3'd1, 36, 50);
    test_random_segment(3'd4, 36, 50);
    test_random_segment(3'd0, 36, 50);
    test_random_segment(3'd7, 50, 36);
    test_random_segment(3'd2, 50, 36);
    test_random_segment(3'd5, 50, 36);
    test_random_segment(3'd6, 0, 0);
    test_random_segment(3'd3, 0, 0);

    wait_results(READ_WAIT);
    $display("Sent %0d items, checked %0d bin reads across %0d channel settings,",
             items_sent, reads_checked, settings_used);
    $display("with idle and stall patterns on both sides and one long output hold-off.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d reads still pending", expected_bins.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
